// File: hdl/ipac_pkg.sv
// Shared types, constants and helpers for the icon pixel alpha compositor.
package ipac_pkg;

    localparam logic [7:0] FULL_LEVEL = 8'hFF;

    // Magenta shape key emitted for fully transparent pixels
    localparam logic [7:0] KEY_RED   = 8'hFF;
    localparam logic [7:0] KEY_GREEN = 8'h00;
    localparam logic [7:0] KEY_BLUE  = 8'hFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_GLOW   = 2'd1,
        REG_FORMAT = 2'd2
    } cfg_idx_t;

    // Foreground pixel formats; the unused code is handled as RGBA
    typedef enum logic [1:0] {
        FMT_GRAY       = 2'd0,
        FMT_GRAY_ALPHA = 2'd1,
        FMT_RGBA       = 2'd2
    } fmt_t;

    // Configuration state seen by the datapath
    typedef struct packed {
        logic [7:0] offset;
        logic       glow;
        logic [1:0] fmt;
    } cfg_t;

    // Decoded foreground: expanded channels and effective alpha
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       key;
    } pix_t;

    // floor(x / 255) for x up to 255*255: ((x + 1) + ((x + 1) >> 8)) >> 8
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] inc;
        logic [16:0] sum;
        inc = {1'b0, x} + 17'd1;
        sum = inc + {9'd0, inc[15:8]};
        return sum[15:8];
    endfunction

endpackage

// File: hdl/ipac_alpha.sv
// Foreground format expansion and effective alpha computation.
module ipac_alpha
    import ipac_pkg::*;
(
    input  cfg_t       cfg,
    input  logic [7:0] fg_red,
    input  logic [7:0] fg_green,
    input  logic [7:0] fg_blue,
    input  logic [7:0] fg_alpha,
    output pix_t       pix
);

    logic [7:0] green_sel;
    logic [7:0] blue_sel;
    logic [7:0] raw_alpha;
    logic [7:0] eff_alpha;

    // Expand gray formats to equal channels; plain gray is opaque
    always_comb
    begin
        unique case (cfg.fmt)
            FMT_GRAY:
            begin
                green_sel = fg_red;
                blue_sel  = fg_red;
                raw_alpha = FULL_LEVEL;
            end
            FMT_GRAY_ALPHA:
            begin
                green_sel = fg_red;
                blue_sel  = fg_red;
                raw_alpha = fg_alpha;
            end
            default:
            begin
                green_sel = fg_green;
                blue_sel  = fg_blue;
                raw_alpha = fg_alpha;
            end
        endcase
    end

    // Glow uses raw alpha, otherwise subtract the offset saturating at zero
    always_comb
    begin
        if (cfg.glow)
            eff_alpha = raw_alpha;
        else if (raw_alpha > cfg.offset)
            eff_alpha = raw_alpha - cfg.offset;
        else
            eff_alpha = 8'd0;
    end

    assign pix = '{red:   fg_red,
                   green: green_sel,
                   blue:  blue_sel,
                   alpha: eff_alpha,
                   key:   (eff_alpha == 8'd0)};

endmodule

// File: hdl/ipac_blend.sv
// One channel of the alpha blend: bg*(255-a)/255 + fg*a/255, each term floored.
module ipac_blend
    import ipac_pkg::*;
(
    input  logic [7:0] bg,
    input  logic [7:0] fg,
    input  logic [7:0] alpha,
    output logic [7:0] mix
);

    logic [7:0]  inv_alpha;
    logic [15:0] bg_prod;
    logic [15:0] fg_prod;
    logic [8:0]  sum;

    assign inv_alpha = FULL_LEVEL - alpha;
    assign bg_prod   = bg * inv_alpha;
    assign fg_prod   = fg * alpha;

    // The two floored terms never sum above 255
    assign sum = {1'b0, div255(bg_prod)} + {1'b0, div255(fg_prod)};
    assign mix = sum[7:0];

endmodule

// File: hdl/icon_pixel_alpha_composite.sv
// Top level: input register, alpha decode and blend, result register.
//
//  Channel  Direction  Transaction           Payload
//  s_*      in         foreground+background  s_tdata[55:0]
//  m_*      out        composited pixel       m_tdata[23:0], m_tuser (shape key)
//  cfg_*    in         register write         cfg_index[1:0], cfg_data[7:0]
//
// Two register stages: a pixel taken into the input register moves on to the
// result register and is offered from there; one pixel per clock is sustained
// while m_tready stays high.
// Both stages advance together when the result register is empty or taken,
// so while a result waits the input register can still take one pixel.
// Reset clears the valid flags and loads offset 0, glow off, format RGBA.
// cfg_ready is always high; writes to index 3 are dropped.
module icon_pixel_alpha_composite
    import ipac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // fg_red, fg_green, fg_blue, fg_alpha, bg_red, bg_green, bg_blue
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_red, out_green, out_blue
    output logic [23:0] m_tdata,
    // shape_key
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [55:0] in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [23:0] out_data_reg;
    logic        out_key_reg;
    logic        advance;
    pix_t        pix;
    logic [7:0]  mix_red;
    logic [7:0]  mix_green;
    logic [7:0]  mix_blue;
    logic [23:0] result;

    // Configuration register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OFFSET: cfg_next.offset = cfg_data;
                REG_GLOW:   cfg_next.glow   = cfg_data[0];
                REG_FORMAT: cfg_next.fmt    = cfg_data[1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset <= 8'd0;
            cfg_reg.glow   <= 1'b0;
            cfg_reg.fmt    <= FMT_RGBA;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline flow control
    assign advance        = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
    end

    // Alpha decode and per-channel blend
    ipac_alpha u_alpha (
        .cfg      (cfg_reg),
        .fg_red   (in_data_reg[7:0]),
        .fg_green (in_data_reg[15:8]),
        .fg_blue  (in_data_reg[23:16]),
        .fg_alpha (in_data_reg[31:24]),
        .pix      (pix)
    );

    ipac_blend u_blend_red (
        .bg    (in_data_reg[39:32]),
        .fg    (pix.red),
        .alpha (pix.alpha),
        .mix   (mix_red)
    );

    ipac_blend u_blend_green (
        .bg    (in_data_reg[47:40]),
        .fg    (pix.green),
        .alpha (pix.alpha),
        .mix   (mix_green)
    );

    ipac_blend u_blend_blue (
        .bg    (in_data_reg[55:48]),
        .fg    (pix.blue),
        .alpha (pix.alpha),
        .mix   (mix_blue)
    );

    // Shape key replaces the blend when the pixel is fully transparent
    assign result = pix.key ? {KEY_BLUE, KEY_GREEN, KEY_RED}
                            : {mix_blue, mix_green, mix_red};

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result;
            out_key_reg  <= pix.key;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_key_reg;

    // A keyed result always carries magenta
    a_key_color: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == {KEY_BLUE, KEY_GREEN, KEY_RED})
        else $error("shape key result is not magenta");

    // With the result register empty the input side is never stalled
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Both stages full and output stalled blocks new input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline is full");

    // A pixel in the input register moves to the output when the pipe advances
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> m_tvalid)
        else $error("pixel lost between stages");

endmodule

// File: tb/tb_icon_pixel_alpha_composite.sv
// Testbench for the icon pixel alpha compositor: directed and random pixels.
module tb_icon_pixel_alpha_composite;
    import ipac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it, and the format code left undefined
    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam logic [1:0] FMT_UNDEFINED = 2'd3;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned PIPE_LATENCY    = 4;
    localparam int unsigned RANDOM_PHASES   = 13;
    localparam int unsigned PIXELS_PER_PHASE = 150;

    // Input transaction, fg_red in the lowest byte
    typedef struct packed {
        logic [7:0] bg_blue;
        logic [7:0] bg_green;
        logic [7:0] bg_red;
        logic [7:0] fg_alpha;
        logic [7:0] fg_blue;
        logic [7:0] fg_green;
        logic [7:0] fg_red;
    } pixel_in_t;

    // One composited result
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       key;
    } composite_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Register mirror used for prediction
    logic [7:0]  offset_q = 8'd0;
    logic        glow_q = 1'b0;
    logic [1:0]  fmt_q = FMT_RGBA;

    composite_t  pending_composites[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_en = 1'b1;

    icon_pixel_alpha_composite u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("icon_pixel_alpha_composite: mismatch");
            $finish;
        end
    end

    // Receiver: drops m_tready at random, about 7 times in 100, while idling is enabled
    always @(posedge clk)
    begin
        m_tready <= !(idle_en && ($urandom_range(99) < 7));
    end

    // floor(bg*(255-a)/255) + floor(fg*a/255)
    function automatic logic [7:0] blend_channel(input logic [7:0] bg, input logic [7:0] fg,
                                                 input logic [7:0] a);
        int unsigned sum;
        sum = (int'(bg) * (int'(FULL_LEVEL) - int'(a))) / int'(FULL_LEVEL)
            + (int'(fg) * int'(a)) / int'(FULL_LEVEL);
        return sum[7:0];
    endfunction

    // Expected result for one pixel under the mirrored configuration
    function automatic composite_t composite_pixel(input pixel_in_t px);
        composite_t res;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [7:0] eff;
        r = px.fg_red;
        g = px.fg_green;
        b = px.fg_blue;
        a = px.fg_alpha;
        case (fmt_q)
            FMT_GRAY:
            begin
                g = r;
                b = r;
                a = FULL_LEVEL;
            end
            FMT_GRAY_ALPHA:
            begin
                g = r;
                b = r;
            end
            default: ;
        endcase
        if (glow_q)
            eff = a;
        else
            eff = (a > offset_q) ? a - offset_q : 8'd0;
        if (eff == 8'd0)
        begin
            res.red   = KEY_RED;
            res.green = KEY_GREEN;
            res.blue  = KEY_BLUE;
            res.key   = 1'b1;
        end
        else
        begin
            res.red   = blend_channel(px.bg_red, r, eff);
            res.green = blend_channel(px.bg_green, g, eff);
            res.blue  = blend_channel(px.bg_blue, b, eff);
            res.key   = 1'b0;
        end
        return res;
    endfunction

    // Mirror register writes, predict accepted pixels, check accepted results
    always @(posedge clk)
    begin : check_results
        composite_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OFFSET: offset_q = cfg_data;
                    REG_GLOW:   glow_q   = cfg_data[0];
                    REG_FORMAT: fmt_q    = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_composites.push_back(composite_pixel(pixel_in_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                if (pending_composites.size() == 0)
                begin
                    $error("result with no pixel outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_composites.pop_front();
                    if (m_tdata[7:0] !== want.red)
                    begin
                        $error("out_red: expected %0d, actual %0d", want.red, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[15:8] !== want.green)
                    begin
                        $error("out_green: expected %0d, actual %0d", want.green,
                               m_tdata[15:8]);
                        mismatch_count++;
                    end
                    if (m_tdata[23:16] !== want.blue)
                    begin
                        $error("out_blue: expected %0d, actual %0d", want.blue,
                               m_tdata[23:16]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.key)
                    begin
                        $error("shape_key: expected %0d, actual %0d", want.key, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic pixel_in_t make_pixel(input logic [7:0] fr, input logic [7:0] fg,
                                             input logic [7:0] fb, input logic [7:0] fa,
                                             input logic [7:0] br, input logic [7:0] bgn,
                                             input logic [7:0] bb);
        pixel_in_t px;
        px.fg_red   = fr;
        px.fg_green = fg;
        px.fg_blue  = fb;
        px.fg_alpha = fa;
        px.bg_red   = br;
        px.bg_green = bgn;
        px.bg_blue  = bb;
        return px;
    endfunction

    // One pixel transaction; tvalid stays high so back-to-back pixels need no gap
    task automatic send_pixel(input pixel_in_t px);
        while (idle_en && ($urandom_range(99) < 7))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic wait_composites_done();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_composites.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // One register write transaction; cfg_valid stays high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic release_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write all three registers once the block is idle
    task automatic set_config(input logic [7:0] offset_val, input logic [7:0] glow_val,
                              input logic [7:0] fmt_val);
        wait_composites_done();
        write_reg(REG_OFFSET, offset_val);
        write_reg(REG_GLOW, glow_val);
        write_reg(REG_FORMAT, fmt_val);
        release_cfg();
    endtask

    // Reset values: RGBA, no offset, no glow
    task automatic test_reset_defaults();
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h00, 8'h40, 8'h50, 8'h60));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 8'h01, 8'h00, 8'hFF, 8'h7F));
        send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h80, 8'h9A, 8'hBC, 8'hDE));
    endtask

    // Gray expansion, gray opacity and the undefined format code
    task automatic test_formats();
        set_config(8'd0, 8'd0, FMT_GRAY);
        send_pixel(make_pixel(8'h80, 8'h11, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        set_config(8'd0, 8'd0, FMT_GRAY_ALPHA);
        send_pixel(make_pixel(8'hC0, 8'h01, 8'h02, 8'h40, 8'h10, 8'h20, 8'h30));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03));
        set_config(8'd0, 8'd0, FMT_UNDEFINED);
        send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'h99, 8'h44, 8'h55, 8'h66));
    endtask

    // Offset saturation at zero, and glow bypassing the offset
    task automatic test_offset_and_glow();
        set_config(8'd200, 8'd0, FMT_RGBA);
        send_pixel(make_pixel(8'hAA, 8'h55, 8'hF0, 8'd200, 8'h0F, 8'hA5, 8'h5A));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'd201, 8'h00, 8'h00, 8'h00));
        set_config(8'd200, 8'd1, FMT_RGBA);
        send_pixel(make_pixel(8'hAA, 8'h55, 8'hF0, 8'd200, 8'h0F, 8'hA5, 8'h5A));
        send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h05, 8'h06));
        set_config(8'd255, 8'd0, FMT_GRAY);
        send_pixel(make_pixel(8'h7E, 8'h00, 8'h00, 8'h00, 8'h81, 8'h82, 8'h83));
    endtask

    // Oversized values keep their low bits; writes to the unused index are dropped
    task automatic test_register_edges();
        wait_composites_done();
        write_reg(REG_OFFSET, 8'd16);
        write_reg(REG_GLOW, 8'hFE);
        write_reg(REG_FORMAT, 8'hFE);
        write_reg(REG_UNUSED, 8'hFF);
        release_cfg();
        send_pixel(make_pixel(8'h20, 8'h40, 8'h60, 8'd16, 8'hE0, 8'hC0, 8'hA0));
        send_pixel(make_pixel(8'h20, 8'h40, 8'h60, 8'd17, 8'hE0, 8'hC0, 8'hA0));
        set_config(8'd0, 8'h03, 8'h07);
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00));
    endtask

    // Random pixels over a series of settings, extremes first
    task automatic test_random_phases();
        pixel_in_t   px;
        logic [7:0]  off;
        int unsigned phase;
        int unsigned n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: off = 8'd0;
                1: off = 8'd255;
                2: off = 8'd0;
                3: off = 8'd255;
                4: off = 8'd1;
                default: off = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
            endcase
            case (phase)
                0: set_config(off, 8'd0, FMT_RGBA);
                1: set_config(off, 8'd0, FMT_RGBA);
                2: set_config(off, 8'd1, FMT_GRAY);
                3: set_config(off, 8'd1, FMT_GRAY_ALPHA);
                4: set_config(off, 8'd0, FMT_UNDEFINED);
                default:
                begin
                    wait_composites_done();
                    if ($urandom_range(1))
                        write_reg(REG_UNUSED, 8'($urandom));
                    write_reg(REG_OFFSET, off);
                    write_reg(REG_GLOW, 8'($urandom));
                    write_reg(REG_FORMAT, 8'($urandom));
                    release_cfg();
                end
            endcase
            // one phase runs without any idling on either side
            idle_en = (phase != 6);
            for (n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                if (phase == 8 && n == PIXELS_PER_PHASE / 2)
                    wait_composites_done();
                px = pixel_in_t'(56'({$urandom, $urandom}));
                case ($urandom_range(9))
                    0: px.fg_alpha = 8'h00;
                    1: px.fg_alpha = 8'hFF;
                    2: px.fg_alpha = off + 8'($urandom_range(2)) - 8'd1;
                    default: ;
                endcase
                send_pixel(px);
            end
            idle_en = 1'b1;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_formats();
        test_offset_and_glow();
        test_register_edges();
        test_random_phases();
        wait_composites_done();
        if (mismatch_count == 0)
            $display("icon_pixel_alpha_composite: match");
        else
            $display("icon_pixel_alpha_composite: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hdl/ipac_pkg.sv
hdl/ipac_alpha.sv
hdl/ipac_blend.sv
hdl/icon_pixel_alpha_composite.sv
tb/tb_icon_pixel_alpha_composite.sv
